// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg - shared definitions for the point-in-polygon crossing test
// Default sizes, action codes and the status bundle of the edge datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  typedef struct packed {
    logic busy;    // edge beats still in the pipe
    logic parity;  // running crossing parity
  } pip_edge_stat_t;

endpackage

// ----- hw/rtl/pip_if.sv -----
// ----------------------------------------------------------------------------
// pip_in_if / pip_out_if - valid/ready channels of the crossing test
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface pip_in_if #(
  parameter int IDX_W      = $clog2(pip_pkg::MAX_VERTICES_DEF),
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [IDX_W-1:0]             vertex_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic                         group_start;

  modport source (output valid, action, vertex_index, coord_x, coord_y, group_start,
                  input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, group_start,
                  output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic any_inside;

  modport source (output valid, inside_res, any_inside, input ready);
  modport sink   (input valid, inside_res, any_inside, output ready);
endinterface

// ----- hw/rtl/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/pip_edge.sv -----
// ----------------------------------------------------------------------------
// pip_edge - per-edge crossing datapath
// Takes one vertex beat per cycle from the store, pairs it with the previous
// one and toggles the parity when the edge crosses at or right of the query point.
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         rd_vld,
  input  logic                         rd_first,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pip_pkg::pip_edge_stat_t      stat
);
  import pip_pkg::*;

  localparam int C = COORD_BITS;

  logic signed [C-1:0]   prev_x_r, prev_y_r;

  logic signed [C:0]     a_nxt, b_nxt, c_nxt, d_nxt;
  logic                  strad_nxt, v1_nxt;
  logic signed [C:0]     a1_r, b1_r, c1_r, d1_r;
  logic                  v1_r, strad1_r, dyneg1_r;

  logic signed [2*C+1:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic                  v2_r, strad2_r, dyneg2_r;

  logic                  left;
  logic                  inside_r, inside_nxt;

  // i is the beat arriving now, j the one before it
  assign a_nxt     = {px[C-1], px} - {rd_x[C-1], rd_x};
  assign b_nxt     = {prev_y_r[C-1], prev_y_r} - {rd_y[C-1], rd_y};
  assign c_nxt     = {prev_x_r[C-1], prev_x_r} - {rd_x[C-1], rd_x};
  assign d_nxt     = {py[C-1], py} - {rd_y[C-1], rd_y};
  assign strad_nxt = (rd_y >= py) != (prev_y_r >= py);
  assign v1_nxt    = rd_vld && !rd_first;

  assign p1_nxt = (2*C+2)'(a1_r) * (2*C+2)'(b1_r);
  assign p2_nxt = (2*C+2)'(c1_r) * (2*C+2)'(d1_r);

  // straddling edge has dy != 0; sign of dy picks the comparison
  assign left = dyneg2_r ? (p1_r >= p2_r) : (p1_r <= p2_r);

  always_comb begin
    inside_nxt = inside_r;
    if (clr) begin
      inside_nxt = 1'b0;
    end else if (v2_r && strad2_r && left) begin
      inside_nxt = !inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      v1_r     <= v1_nxt;
      v2_r     <= v1_r;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    a1_r     <= a_nxt;
    b1_r     <= b_nxt;
    c1_r     <= c_nxt;
    d1_r     <= d_nxt;
    strad1_r <= strad_nxt;
    dyneg1_r <= b_nxt[C];
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    strad2_r <= strad1_r;
    dyneg2_r <= dyneg1_r;
  end

  assign stat.busy   = v1_r || v2_r;
  assign stat.parity = inside_r;

endmodule

// ----- hw/rtl/point_in_polygon_crossing_test_top.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_top - crossing-number point-in-polygon test
// Vertex store in one RAM; a test beat sweeps all stored edges for a parity.
// ----------------------------------------------------------------------------
// Vertex write: stored, no result.
// Test, from accept to result: n + 1 reads (n = vertices in use, none when n is 0)
//   of the single RAM port, one a cycle, then subtract / multiply / compare.
// One test at a time; the next beat is taken as the result appears, but a result
//   still waiting for ready holds back the next result, and so the next beat.
// Reset (synchronous, rst_n low) clears count, accumulator and control, not the RAM.
module point_in_polygon_crossing_test_top #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  localparam int IDX_W       = $clog2(MAX_VERTICES),
  localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  pip_in_if.sink           in_ch,
  pip_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);
  import pip_pkg::*;

  localparam int C = COORD_BITS;
  localparam logic [IDX_W:0]   IDX_LIM = (IDX_W+1)'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] N_MAX   = CNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_sat, n_m1;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic signed [C-1:0] px_r, py_r;
  logic             grp_r;
  logic             acc_r, acc_nxt;
  logic             rvalid_r, rfirst_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_inside_r, out_inside_nxt;
  logic             out_any_r, out_any_nxt;

  logic             in_acc, is_test, out_free, out_load, hit_any;
  logic             ram_we, ram_re;
  logic [2*C-1:0]   ram_rdata;
  pip_edge_stat_t   edge_stat;

  assign n_sat    = (cnt_r > N_MAX) ? N_MAX : cnt_r;
  assign n_m1     = n_sat - 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_test  = in_acc && (in_ch.action == ACT_TEST);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_DRAIN) && !rvalid_r && !edge_stat.busy && out_free;
  assign hit_any  = (grp_r ? 1'b0 : acc_r) | edge_stat.parity;

  assign ram_we = in_acc && (in_ch.action == ACT_WRITE) &&
                  ({1'b0, in_ch.vertex_index} < IDX_LIM);
  assign ram_re = (state_r == ST_SCAN);

  pip_ram #(
    .WIDTH (2*C),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.vertex_index),
    .wdata ({in_ch.coord_x, in_ch.coord_y}),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  pip_edge #(
    .COORD_BITS (C)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (is_test),
    .rd_vld   (rvalid_r),
    .rd_first (rfirst_r),
    .rd_x     ($signed(ram_rdata[2*C-1:C])),
    .rd_y     ($signed(ram_rdata[C-1:0])),
    .px       (px_r),
    .py       (py_r),
    .stat     (edge_stat)
  );

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_inside_nxt = out_inside_r;
    out_any_nxt    = out_any_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_test) begin
          // last vertex first, so edge (0, n-1) comes out of the first pair
          addr_nxt  = n_m1[IDX_W-1:0];
          step_nxt  = '0;
          state_nxt = (n_sat == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = (step_r == '0) ? '0 : addr_r + 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == n_sat) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = edge_stat.parity;
          out_any_nxt    = hit_any;
          acc_nxt        = hit_any;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
      rvalid_r    <= 1'b0;
      rfirst_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      rvalid_r    <= ram_re;
      rfirst_r    <= ram_re && (step_r == '0);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    step_r       <= step_nxt;
    out_inside_r <= out_inside_nxt;
    out_any_r    <= out_any_nxt;
    if (is_test) begin
      px_r  <= in_ch.coord_x;
      py_r  <= in_ch.coord_y;
      grp_r <= in_ch.group_start;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = out_inside_r;
  assign out_ch.any_inside = out_any_r;

  // store is never written while a sweep reads it
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("vertex RAM written during sweep");

  a_test_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    is_test |=> (state_r != ST_IDLE))
    else $error("test beat did not start a sweep");

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!rvalid_r && !edge_stat.busy))
    else $error("result taken with edges in flight");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r <= n_sat))
    else $error("sweep ran past vertex count");

  a_any_covers_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> out_any_r)
    else $error("accumulator misses an inside hit");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for point_in_polygon_crossing_test_top
// Loads polygons into the vertex store, sweeps the vertex count over its
// range and fires query points at each one. An in-bench crossing-parity model
// predicts inside and collision flags; every result beat is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import pip_pkg::*;

  localparam int MAX_V          = MAX_VERTICES_DEF;
  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int IDX_W          = $clog2(MAX_V);
  localparam int CNT_W          = $clog2(MAX_V + 1);
  localparam int SETTLE_CYCLES  = MAX_V + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic in_poly;
    logic any_hit;
  } hit_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pip_in_if #(.IDX_W(IDX_W), .COORD_BITS(COORD_W)) in_bus ();
  pip_out_if out_bus ();

  point_in_polygon_crossing_test_top #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (COORD_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state
  coord_t           vert_x [MAX_V];
  coord_t           vert_y [MAX_V];
  logic [CNT_W-1:0] vert_count;
  logic             hit_acc;
  hit_t             expected_hits [$];

  int unsigned fault_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_req;

  // crossing parity over all stored edges; products are exact at 2*COORD_W+2 bits
  function automatic logic point_inside(input coord_t px, input coord_t py);
    int unsigned                 n;
    int unsigned                 i, j;
    logic                        parity;
    logic signed [COORD_W:0]     d_y, dx_p, dx_e, dy_p;
    logic signed [2*COORD_W+1:0] lhs, rhs;
    n      = (vert_count > MAX_V) ? MAX_V : vert_count;
    parity = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      if ((vert_y[i] >= py) != (vert_y[j] >= py)) begin
        d_y  = (COORD_W+1)'(vert_y[j]) - (COORD_W+1)'(vert_y[i]);
        dx_p = (COORD_W+1)'(px) - (COORD_W+1)'(vert_x[i]);
        dx_e = (COORD_W+1)'(vert_x[j]) - (COORD_W+1)'(vert_x[i]);
        dy_p = (COORD_W+1)'(py) - (COORD_W+1)'(vert_y[i]);
        lhs  = (2*COORD_W+2)'(dx_p) * (2*COORD_W+2)'(d_y);
        rhs  = (2*COORD_W+2)'(dx_e) * (2*COORD_W+2)'(dy_p);
        // sign of dy flips the sense of the cross-multiplied comparison
        if ((d_y > 0) ? (lhs <= rhs) : (lhs >= rhs)) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // result check first, then prediction for the beat accepted on the same edge
  always @(posedge clk) begin
    hit_t want, got;
    logic res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.in_poly = out_bus.inside_res;
      got.any_hit = out_bus.any_inside;
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result beat: inside_res %0b any_inside %0b",
                 $time, got.in_poly, got.any_hit);
        fault_count++;
      end else begin
        want = expected_hits.pop_front();
        if (got.in_poly !== want.in_poly) begin
          $display("%0t inside_res mismatch: expected %0b actual %0b",
                   $time, want.in_poly, got.in_poly);
          fault_count++;
        end
        if (got.any_hit !== want.any_hit) begin
          $display("%0t any_inside mismatch: expected %0b actual %0b",
                   $time, want.any_hit, got.any_hit);
          fault_count++;
        end
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      if (in_bus.action == ACT_WRITE) begin
        vert_x[in_bus.vertex_index] = in_bus.coord_x;
        vert_y[in_bus.vertex_index] = in_bus.coord_y;
      end else begin
        if (in_bus.group_start) hit_acc = 1'b0;
        res           = point_inside(in_bus.coord_x, in_bus.coord_y);
        hit_acc       = hit_acc | res;
        want.in_poly  = res;
        want.any_hit  = hit_acc;
        expected_hits = {expected_hits, want};
      end
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[COORD_W-1:0];
  endfunction

  function automatic coord_t near_coord(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(span)) - span / 2;
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return v[COORD_W-1:0];
  endfunction

  // one beat; valid stays up when the next beat follows with no gap
  task automatic send_item(input logic act, input logic [IDX_W-1:0] slot,
                           input coord_t x, input coord_t y, input logic grp);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= act;
    in_bus.vertex_index <= slot;
    in_bus.coord_x      <= x;
    in_bus.coord_y      <= y;
    in_bus.group_start  <= grp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic put_vertex(input int unsigned slot, input coord_t x, input coord_t y,
                            input logic grp);
    send_item(ACT_WRITE, slot[IDX_W-1:0], x, y, grp);
  endtask

  task automatic put_query(input coord_t x, input coord_t y, input logic grp);
    int unsigned slot;
    slot = $urandom_range(MAX_V - 1);
    send_item(ACT_TEST, slot[IDX_W-1:0], x, y, grp);
  endtask

  // idle the block: all results in, then room for a sweep still running
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int unsigned value);
    settle();
    cfg_wdata <= value[CNT_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    vert_count = value[CNT_W-1:0];
  endtask

  task automatic pick_query(input int cx, input int cy, input int span,
                            output coord_t qx, output coord_t qy);
    int unsigned n, k;
    n  = (vert_count > MAX_V) ? MAX_V : vert_count;
    k  = (n == 0) ? 0 : $urandom_range(n - 1);
    qx = near_coord(cx, span + span / 4);
    qy = near_coord(cy, span + span / 4);
    case ($urandom_range(9))
      0: begin
        qx = rand_coord();
        qy = rand_coord();
      end
      1: if (n != 0) begin
        qx = vert_x[k];
        qy = vert_y[k];
      end
      2: if (n != 0) qy = vert_y[k];  // ray through a vertex
      3: if (n != 0) qx = vert_x[k];
      default: ;
    endcase
  endtask

  task automatic test_empty_polygon();
    put_query(C_MIN, C_MAX, 1'b1);
  endtask

  task automatic test_extreme_square();
    put_vertex(0, C_MIN, C_MIN, 1'b1);  // group flag on a write is ignored
    put_vertex(1, C_MAX, C_MIN, 1'b0);
    put_vertex(2, C_MAX, C_MAX, 1'b0);
    put_vertex(3, C_MIN, C_MAX, 1'b0);
    set_vertex_count(4);
    put_query(coord_t'(0), coord_t'(0), 1'b1);
    put_query(C_MAX, coord_t'(0), 1'b0);
    put_query(C_MIN, coord_t'(0), 1'b0);
    put_query(coord_t'(0), C_MAX, 1'b0);
    put_query(coord_t'(0), C_MIN, 1'b0);
    put_query(C_MAX, C_MAX, 1'b0);
    put_query(C_MIN, C_MIN, 1'b0);
    // lower-right triangle of the same store
    set_vertex_count(3);
    put_query(C_MIN, C_MAX, 1'b1);
    put_query(coord_t'(16384), coord_t'(-16384), 1'b0);
    put_query(coord_t'(-1), coord_t'(-1), 1'b0);
  endtask

  task automatic test_degenerate_counts();
    set_vertex_count(1);
    put_query(C_MIN, C_MIN, 1'b1);
    put_query(coord_t'(0), coord_t'(0), 1'b0);
    set_vertex_count(2);
    put_query(coord_t'(0), coord_t'(0), 1'b1);
    put_query(coord_t'(0), C_MIN, 1'b0);
    set_vertex_count(0);
    put_query(coord_t'(0), coord_t'(0), 1'b0);
  endtask

  task automatic run_polygon_phase(input int unsigned count_val, input int unsigned mode,
                                   input int unsigned n_items);
    int          cx, cy, span;
    int unsigned n, k, sent, glen, g;
    coord_t      qx, qy;
    set_vertex_count(count_val);
    case (mode)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 77; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 77; end
      default: begin src_idle_pct = 37; sink_stall_pct = 37; end
    endcase
    if ($urandom_range(3) == 0) begin
      cx   = 0;
      cy   = 0;
      span = 65535;
    end else begin
      cx   = int'($urandom_range(48000)) - 24000;
      cy   = int'($urandom_range(48000)) - 24000;
      span = 1 << $urandom_range(4, 14);
    end
    n = (count_val > MAX_V) ? MAX_V : count_val;
    for (k = 0; k < n; k++)
      put_vertex(k, near_coord(cx, span), near_coord(cy, span), 1'($urandom_range(1)));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        put_vertex($urandom_range(MAX_V - 1), near_coord(cx, span), near_coord(cy, span),
                   1'($urandom_range(1)));
        sent++;
      end else begin
        // a collision group: cleared on its first point, now and then left open
        glen = $urandom_range(1, 6);
        for (g = 0; g < glen && sent < n_items; g++) begin
          pick_query(cx, cy, span, qx, qy);
          put_query(qx, qy, (g == 0) ^ ($urandom_range(19) == 0));
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_polygons();
    int unsigned p, cnt, r;
    for (p = 0; p < 16; p++) begin
      case (p)
        0: cnt = 127;  // saturates to the store depth
        1: cnt = MAX_V;
        2: cnt = 0;
        3: cnt = 1;
        4: cnt = 2;
        5: cnt = 3;
        default: begin
          r = $urandom_range(9);
          if (r < 7)      cnt = $urandom_range(3, 12);
          else if (r < 9) cnt = $urandom_range(13, 40);
          else            cnt = $urandom_range(41, MAX_V);
        end
      endcase
      run_polygon_phase(cnt, p % 4, 60);
    end
  endtask

  // result side blocked for a long stretch while queries keep coming
  task automatic test_backpressure();
    int unsigned k;
    coord_t      qx, qy;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    for (k = 0; k < 12; k++) begin
      pick_query(0, 0, 65535, qx, qy);
      put_query(qx, qy, k == 0);
    end
    src_idle_pct   = 37;
    sink_stall_pct = 37;
  endtask

  initial begin
    fault_count         = 0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    hold_req            = 1'b0;
    vert_count          = '0;
    hit_acc             = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_WRITE;
    in_bus.vertex_index = '0;
    in_bus.coord_x      = '0;
    in_bus.coord_y      = '0;
    in_bus.group_start  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_polygon();
    test_extreme_square();
    test_degenerate_counts();
    test_random_polygons();
    test_backpressure();

    settle();
    if (fault_count == 0 && expected_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
